// File: src/srg_pkg.sv
// Shared types, register indexes and correction polynomial tables for the pair kick block.
package srg_pkg;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int POLY_W = 40;
  localparam int ACC_W  = 48;
  localparam int CPL_FRAC = 24;
  localparam int WIDE_W = 69;

  localparam logic [1:0] REG_COUPLING     = 2'd0;
  localparam logic [1:0] REG_CUTOFF_SQ    = 2'd1;
  localparam logic [1:0] REG_SOFTENING_SQ = 2'd2;
  localparam logic [1:0] REG_POLY_ORDER   = 2'd3;

  localparam logic [2:0] ORD4 = 3'd4;
  localparam logic [2:0] ORD5 = 3'd5;
  localparam logic [2:0] ORD6 = 3'd6;

  localparam logic signed [WIDE_W-1:0] I32_MAX  = 69'sh0_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] I32_MIN  = -69'sh0_8000_0000;
  localparam logic signed [WIDE_W-1:0] ACC_MAX  = 69'sh7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] ACC_MIN  = -69'sh8000_0000_0000;
  localparam logic signed [WIDE_W-1:0] POLY_MAX = 69'sh7F_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] POLY_MIN = -69'sh80_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D_MUL, ST_D_ACC, ST_CUT, ST_SQRT, ST_P_MUL, ST_P_LOAD, ST_DIV,
    ST_POLY_INIT, ST_POLY_HI, ST_POLY_LO, ST_POLY_ADD, ST_G, ST_F_MUL, ST_F_ACC,
    ST_FIN, ST_K_HI, ST_K_LO, ST_K_ADD
  } st_t;

  function automatic logic poly_on(input logic [2:0] order);
    return (order == ORD4) || (order == ORD5) || (order == ORD6);
  endfunction

  // Q.32 Horner coefficients, index 0 is the constant term
  function automatic logic signed [31:0] poly_coef(input logic [2:0] order,
                                                   input logic [2:0] k);
    logic signed [31:0] c;
    c = '0;
    case (order)
      ORD6: begin
        case (k)
          3'd0: c = 32'sd1165787268;
          3'd1: c = -32'sd336465161;
          3'd2: c = 32'sd57175464;
          3'd3: c = -32'sd6849829;
          3'd4: c = 32'sd568379;
          3'd5: c = -32'sd28493;
          3'd6: c = 32'sd633;
          default: c = '0;
        endcase
      end
      ORD5: begin
        case (k)
          3'd0: c = 32'sd1156750657;
          3'd1: c = -32'sd322542595;
          3'd2: c = 32'sd49309661;
          3'd3: c = -32'sd4694958;
          3'd4: c = 32'sd281282;
          3'd5: c = -32'sd6321;
          default: c = '0;
        endcase
      end
      ORD4: begin
        case (k)
          3'd0: c = 32'sd1132707430;
          3'd1: c = -32'sd294757163;
          3'd2: c = 32'sd37892264;
          3'd3: c = -32'sd2544712;
          3'd4: c = 32'sd70705;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: src/short_range_gravity_pair_kick.sv
// Short-range pair force accumulator and velocity kick, one shared multiplier under a sequencer.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | target, neighbor, velocity (x,y,z), last_neighbor
//   out     | out_valid / out_ready| kicked_vel_x/y/z
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// An item outside the cutoff skips the root, divide, polynomial and force steps (the last
// neighbour still runs the kick). Inside the cutoff the bit-serial root and divide dominate.
// Synchronous active-low reset clears control, configuration and the force accumulators.
// A finished result waits in the output register; the next item is taken meanwhile, and a
// following last neighbour holds before the kick until that beat has left.
module short_range_gravity_pair_kick import srg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_neighbor_x,
  input  logic signed [31:0] in_neighbor_y,
  input  logic signed [31:0] in_neighbor_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic               in_last_neighbor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_kicked_vel_x,
  output logic signed [31:0] out_kicked_vel_y,
  output logic signed [31:0] out_kicked_vel_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int NB  = (34 + FRAC_BITS) / 2;
  localparam int RW  = 2 * NB;
  localparam int QW  = 2 * FRAC_BITS + 1;
  localparam int PW  = PROD_W - FRAC_BITS;
  localparam int IW  = (QW > 32) ? QW : 32;
  localparam int GDW = IW + 2;
  localparam int ITW = (QW > NB) ? QW : NB;
  localparam int CW  = $clog2(ITW + 1);
  localparam int DSW = PROD_W - FRAC_BITS + 2;

  logic signed [31:0] coupling_r;
  logic [31:0]        cutoff_r;
  logic [31:0]        soft_r;
  logic [2:0]         order_r;

  st_t state_r, state_nxt;

  logic signed [32:0]      d_r [3];
  logic signed [31:0]      vel_r [3];
  logic signed [ACC_W-1:0] force_r [3];
  logic signed [31:0]      kv_r [3];
  logic                    last_r;
  logic                    out_valid_r;
  logic [1:0]              ax_r;
  logic [2:0]              k_r;
  logic [CW-1:0]           cnt_r;
  logic [DSW-1:0]          d2sum_r;
  logic [31:0]             d2_r;
  logic [32:0]             e_r;
  logic [RW-1:0]           rad_r;
  logic [NB+1:0]           rem_r;
  logic [NB-1:0]           root_r;
  logic [PW-1:0]           p_r;
  logic [PW-1:0]           drem_r;
  logic [QW-1:0]           num_r;
  logic [QW-1:0]           q_r;
  logic signed [POLY_W-1:0] pacc_r;
  logic [PROD_W-1:0]       mhi_r;
  logic signed [31:0]      g_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;

  srg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  // magnitudes of the multiplier operands; d and force are picked by the axis counter
  logic signed [32:0]      d_sel;
  logic [32:0]             dmag;
  logic [POLY_W-1:0]       pmag;
  logic [31:0]             gmag;
  logic signed [ACC_W-1:0] f_sel;
  logic [ACC_W-1:0]        fmag;
  logic [31:0]             cmag;

  assign d_sel = d_r[ax_r];
  assign dmag  = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
  assign pmag  = POLY_W'(pacc_r[POLY_W-1] ? -41'(pacc_r) : 41'(pacc_r));
  assign gmag  = 32'(g_r[31] ? -33'(g_r) : 33'(g_r));
  assign f_sel = force_r[ax_r];
  assign fmag  = ACC_W'(f_sel[ACC_W-1] ? -49'(f_sel) : 49'(f_sel));
  assign cmag  = 32'(coupling_r[31] ? -33'(coupling_r) : 33'(coupling_r));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_D_MUL: begin
        mul_a = dmag;
        mul_b = dmag;
      end
      ST_P_MUL: begin
        mul_a = e_r;
        mul_b = MUL_W'(root_r);
      end
      ST_POLY_HI: begin
        mul_a = MUL_W'(pmag >> FRAC_BITS);
        mul_b = MUL_W'(d2_r);
      end
      ST_POLY_LO: begin
        mul_a = MUL_W'(pmag[FRAC_BITS-1:0]);
        mul_b = MUL_W'(d2_r);
      end
      ST_F_MUL: begin
        mul_a = dmag;
        mul_b = MUL_W'(gmag);
      end
      ST_K_HI: begin
        mul_a = MUL_W'(fmag[ACC_W-1:CPL_FRAC]);
        mul_b = MUL_W'(cmag);
      end
      ST_K_LO: begin
        mul_a = MUL_W'(fmag[CPL_FRAC-1:0]);
        mul_b = MUL_W'(cmag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // squared distance saturation and softened squared length
  logic [31:0] d2_c;
  logic [32:0] e_c;
  assign d2_c = (d2sum_r > DSW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : d2sum_r[31:0];
  assign e_c  = 33'(d2_c) + 33'(soft_r);

  // root step: two radicand bits a cycle
  logic [NB+3:0] sq_cur, sq_trial;
  logic          sq_ge;
  assign sq_cur   = {rem_r, rad_r[RW-1 -: 2]};
  assign sq_trial = (NB+4)'({root_r, 2'b01});
  assign sq_ge    = sq_cur >= sq_trial;

  // restoring divide step
  logic [PW:0] dv_cur;
  logic        dv_ge;
  assign dv_cur = {drem_r, num_r[QW-1]};
  assign dv_ge  = dv_cur >= {1'b0, p_r};

  // Horner step
  logic [PROD_W:0]          pm_sum;
  logic signed [WIDE_W-1:0] pm_s, pc_s, ph_sum;
  assign pm_sum = (PROD_W+1)'(mhi_r) + (PROD_W+1)'(prod_r >> FRAC_BITS);
  assign pm_s   = signed'({2'b00, pm_sum});
  assign pc_s   = WIDE_W'(poly_coef(order_r, k_r));
  assign ph_sum = pacc_r[POLY_W-1] ? pc_s - pm_s : pc_s + pm_s;

  // pair weight g
  logic [POLY_W-1:0]        pmag_f;
  logic signed [GDW-1:0]    poly_f, inv_s, g_diff;
  logic signed [WIDE_W-1:0] g_wide;
  assign pmag_f = pmag >> (32 - FRAC_BITS);
  assign poly_f = pacc_r[POLY_W-1] ? -signed'(GDW'(pmag_f)) : signed'(GDW'(pmag_f));
  assign inv_s  = (p_r == '0) ? signed'(GDW'(32'h7FFF_FFFF)) : signed'(GDW'(q_r));
  assign g_diff = inv_s - poly_f;
  assign g_wide = WIDE_W'(g_diff);

  // force accumulate
  logic signed [WIDE_W-1:0] ft_s, fa_sum;
  assign ft_s   = signed'(WIDE_W'(prod_r >> FRAC_BITS));
  assign fa_sum = (d_sel[32] != g_r[31]) ? WIDE_W'(f_sel) - ft_s : WIDE_W'(f_sel) + ft_s;

  function automatic logic [PROD_W:0] pm_sum_k();
    return (PROD_W+1)'(mhi_r) + (PROD_W+1)'(prod_r >> CPL_FRAC);
  endfunction

  // kick
  logic signed [WIDE_W-1:0] kt_s, kv_sum;
  assign kt_s   = signed'({2'b00, pm_sum_k()});
  assign kv_sum = (f_sel[ACC_W-1] != coupling_r[31]) ? WIDE_W'(vel_r[ax_r]) - kt_s
                                                      : WIDE_W'(vel_r[ax_r]) + kt_s;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_kicked_vel_x = kv_r[0];
  assign out_kicked_vel_y = kv_r[1];
  assign out_kicked_vel_z = kv_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_D_MUL;
      ST_D_MUL:     state_nxt = ST_D_ACC;
      ST_D_ACC:     state_nxt = (ax_r == 2'd2) ? ST_CUT : ST_D_MUL;
      ST_CUT:       state_nxt = (d2_c < cutoff_r) ? ST_SQRT : ST_FIN;
      ST_SQRT:      if (cnt_r == CW'(1)) state_nxt = ST_P_MUL;
      ST_P_MUL:     state_nxt = ST_P_LOAD;
      ST_P_LOAD:    state_nxt = ST_DIV;
      ST_DIV:       if (cnt_r == CW'(1)) state_nxt = ST_POLY_INIT;
      ST_POLY_INIT: state_nxt = poly_on(order_r) ? ST_POLY_HI : ST_G;
      ST_POLY_HI:   state_nxt = ST_POLY_LO;
      ST_POLY_LO:   state_nxt = ST_POLY_ADD;
      ST_POLY_ADD:  state_nxt = (k_r == 3'd0) ? ST_G : ST_POLY_HI;
      ST_G:         state_nxt = ST_F_MUL;
      ST_F_MUL:     state_nxt = ST_F_ACC;
      ST_F_ACC:     state_nxt = (ax_r == 2'd2) ? ST_FIN : ST_F_MUL;
      ST_FIN: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (!out_valid_r) state_nxt = ST_K_HI;
      end
      ST_K_HI:      state_nxt = ST_K_LO;
      ST_K_LO:      state_nxt = ST_K_ADD;
      ST_K_ADD:     state_nxt = (ax_r == 2'd2) ? ST_IDLE : ST_K_HI;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r <= '0;
      cutoff_r   <= '0;
      soft_r     <= '0;
      order_r    <= ORD6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUPLING:     coupling_r <= signed'(cfg_wdata);
        REG_CUTOFF_SQ:    cutoff_r   <= cfg_wdata;
        REG_SOFTENING_SQ: soft_r     <= cfg_wdata;
        REG_POLY_ORDER:   order_r    <= cfg_wdata[2:0];
        default:          order_r    <= order_r;
      endcase
    end
  end

  // accumulators and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r[0]  <= '0;
      force_r[1]  <= '0;
      force_r[2]  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_F_ACC) begin
        if (fa_sum > ACC_MAX)      force_r[ax_r] <= ACC_W'(ACC_MAX);
        else if (fa_sum < ACC_MIN) force_r[ax_r] <= ACC_W'(ACC_MIN);
        else                       force_r[ax_r] <= ACC_W'(fa_sum);
      end
      if (state_r == ST_K_ADD && ax_r == 2'd2) begin
        force_r[0]  <= '0;
        force_r[1]  <= '0;
        force_r[2]  <= '0;
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          d_r[0]   <= 33'(in_neighbor_x) - 33'(in_target_x);
          d_r[1]   <= 33'(in_neighbor_y) - 33'(in_target_y);
          d_r[2]   <= 33'(in_neighbor_z) - 33'(in_target_z);
          vel_r[0] <= in_vel_x;
          vel_r[1] <= in_vel_y;
          vel_r[2] <= in_vel_z;
          last_r   <= in_last_neighbor;
          ax_r     <= 2'd0;
          d2sum_r  <= '0;
        end
      end
      ST_D_ACC: begin
        d2sum_r <= d2sum_r + DSW'(prod_r >> FRAC_BITS);
        ax_r    <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      ST_CUT: begin
        d2_r   <= d2_c;
        e_r    <= e_c;
        rad_r  <= RW'(e_c) << FRAC_BITS;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(NB);
      end
      ST_SQRT: begin
        rad_r  <= rad_r << 2;
        cnt_r  <= cnt_r - CW'(1);
        if (sq_ge) begin
          rem_r  <= (NB+2)'(sq_cur - sq_trial);
          root_r <= {root_r[NB-2:0], 1'b1};
        end else begin
          rem_r  <= (NB+2)'(sq_cur);
          root_r <= {root_r[NB-2:0], 1'b0};
        end
      end
      ST_P_LOAD: begin
        p_r    <= PW'(prod_r >> FRAC_BITS);
        drem_r <= '0;
        num_r  <= {1'b1, {(QW-1){1'b0}}};
        q_r    <= '0;
        cnt_r  <= CW'(QW);
      end
      ST_DIV: begin
        num_r <= num_r << 1;
        cnt_r <= cnt_r - CW'(1);
        if (dv_ge) begin
          drem_r <= PW'(dv_cur - {1'b0, p_r});
          q_r    <= {q_r[QW-2:0], 1'b1};
        end else begin
          drem_r <= dv_cur[PW-1:0];
          q_r    <= {q_r[QW-2:0], 1'b0};
        end
      end
      ST_POLY_INIT: begin
        if (poly_on(order_r)) begin
          pacc_r <= POLY_W'(poly_coef(order_r, order_r));
          k_r    <= order_r - 3'd1;
        end else begin
          pacc_r <= '0;
        end
      end
      ST_POLY_LO: mhi_r <= prod_r;
      ST_POLY_ADD: begin
        if (ph_sum > POLY_MAX)      pacc_r <= POLY_W'(POLY_MAX);
        else if (ph_sum < POLY_MIN) pacc_r <= POLY_W'(POLY_MIN);
        else                        pacc_r <= POLY_W'(ph_sum);
        k_r <= k_r - 3'd1;
      end
      ST_G: begin
        if (g_wide > I32_MAX)      g_r <= 32'(I32_MAX);
        else if (g_wide < I32_MIN) g_r <= 32'(I32_MIN);
        else                       g_r <= 32'(g_wide);
        ax_r <= 2'd0;
      end
      ST_F_ACC: ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      ST_FIN:   ax_r <= 2'd0;
      ST_K_LO:  mhi_r <= prod_r;
      ST_K_ADD: begin
        if (kv_sum > I32_MAX)      kv_r[ax_r] <= 32'(I32_MAX);
        else if (kv_sum < I32_MIN) kv_r[ax_r] <= 32'(I32_MIN);
        else                       kv_r[ax_r] <= 32'(kv_sum);
        ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (force_r[0] == '0 && force_r[1] == '0 && force_r[2] == '0))
    else $error("accumulators not cleared when result raised");

  a_hold_kick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && last_r && out_valid_r && !out_ready) |=> state_r == ST_FIN)
    else $error("kick started over a waiting result");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_K_ADD)
    else $error("result raised outside the kick step");

endmodule

// File: src/srg_mul.sv
// Shared unsigned multiplier with registered product.
module srg_mul import srg_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
